// File: rtl/core/subtractive_lfg_keystream_xor_unit_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the subtractive LFG keystream unit
// Immediate-implication and next-cycle-implication property wrappers.
// ---------------------------------------------------------------------------
`ifndef SUBTRACTIVE_LFG_KEYSTREAM_XOR_UNIT_ASSERT_SVH
`define SUBTRACTIVE_LFG_KEYSTREAM_XOR_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
// same-cycle implication, masked while reset is asserted
`define SLFG_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("slfg assertion failed");
// next-cycle implication, masked while reset is asserted
`define SLFG_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("slfg assertion failed");
`else
`define SLFG_ASSERT_IMPL(lbl, clk, rstn, ante, cons)
`define SLFG_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif

`endif

// File: rtl/core/slfg_pkg.sv
// ---------------------------------------------------------------------------
// slfg_pkg
// Shared constants, types and index helpers of the subtractive LFG unit.
// ---------------------------------------------------------------------------
package slfg_pkg;

    localparam int TBL_LEN        = 55;
    localparam int MIX_PASSES     = 4;
    localparam int SCATTER_STRIDE = 21;
    localparam int MIX_LAG        = 31;
    localparam int TRAIL_START    = 31;
    localparam int IDX_W          = $clog2(TBL_LEN);
    localparam int PASS_W         = (MIX_PASSES > 1) ? $clog2(MIX_PASSES) : 1;

    localparam logic [7:0]       SEED_RESET   = 8'd176;
    // stride 21 over 54 terms never lands here; memset leaves it zero
    localparam logic [IDX_W-1:0] UNHIT_ENTRY  = IDX_W'(34);
    localparam logic [IDX_W-1:0] SEED_ENTRY   = IDX_W'(TBL_LEN - 1);
    localparam logic [IDX_W-1:0] LAST_ENTRY   = IDX_W'(TBL_LEN - 1);
    localparam logic [IDX_W-1:0] LAST_SCATTER = IDX_W'(TBL_LEN - 2);

    typedef enum logic [2:0] {
        ST_ZERO,
        ST_SEED,
        ST_SCATTER,
        ST_MIX,
        ST_DRAIN,
        ST_IDLE,
        ST_DATA
    } t_state;

    typedef struct packed {
        logic             rd_en;
        logic [IDX_W-1:0] rd_a_addr;
        logic [IDX_W-1:0] rd_b_addr;
        logic             wr_en;
        logic [IDX_W-1:0] wr_addr;
        logic [7:0]       wr_data;
    } t_mem_req;

    typedef struct packed {
        logic [7:0] a;
        logic [7:0] b;
    } t_mem_rsp;

    typedef struct packed {
        logic       vld;
        logic [7:0] data;
    } t_result;

    // x + 1 mod TBL_LEN
    function automatic logic [IDX_W-1:0] idx_inc(input logic [IDX_W-1:0] x);
        logic [IDX_W-1:0] r;
        r = (x == LAST_ENTRY) ? '0 : x + IDX_W'(1);
        return r;
    endfunction

    // x + stride mod TBL_LEN, x known below TBL_LEN
    function automatic logic [IDX_W-1:0] idx_stride(input logic [IDX_W-1:0] x);
        logic [IDX_W:0] s;
        s = {1'b0, x} + (IDX_W+1)'(SCATTER_STRIDE);
        if (s >= (IDX_W+1)'(TBL_LEN)) begin
            s = s - (IDX_W+1)'(TBL_LEN);
        end
        return s[IDX_W-1:0];
    endfunction

    // trail index that belongs to a given lead index
    function automatic logic [IDX_W-1:0] trail_of(input logic [IDX_W-1:0] x);
        logic [IDX_W:0] s;
        s = {1'b0, x} + (IDX_W+1)'(TRAIL_START);
        if (s >= (IDX_W+1)'(TBL_LEN)) begin
            s = s - (IDX_W+1)'(TBL_LEN);
        end
        return s[IDX_W-1:0];
    endfunction

endpackage

// File: rtl/core/subtractive_lfg_keystream_xor_unit.sv
// ---------------------------------------------------------------------------
// subtractive_lfg_keystream_xor_unit
// Byte stream cipher on a 55-entry subtractive lagged Fibonacci generator.
// ---------------------------------------------------------------------------
// Usage: a word with i_func = 0 ciphers i_data_byte (encrypt and decrypt are
// the same) and yields one output word; a word with i_func = 1 reseeds the
// table from the seed register and yields nothing. The seed register (reset
// 176) is written on the cfg channel and only takes effect at the next
// restart. After reset, and after every restart word, the block rebuilds the
// table (one zero write, one seed write, 54 scatter writes, 4 x 55 mixing
// steps, one drain) with o_in_ready low; cfg writes are still taken. A data
// word first reads the lead and trail entries from the table memory, then
// subtracts, writes back and loads the output register. The table has a
// single write port; one shared 8-bit subtractor serves the scatter, mixing
// and data steps. A finished word sits in the output register; the block
// takes the next input meanwhile and only stalls its write-back if the
// output register is still full.
// ---------------------------------------------------------------------------
module subtractive_lfg_keystream_xor_unit import slfg_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // seed config
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [7:0] i_seed_low_byte,
    // input words
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic       i_func,
    input  logic [7:0] i_data_byte,
    // output words
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_out_byte
);

    logic [7:0] r_seed;
    logic       r_out_vld;
    logic [7:0] r_out_byte;
    logic       out_free;
    t_result    res;
    t_mem_req   mem_req;
    t_mem_rsp   mem_rsp;

    // seed register: always writable
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed <= SEED_RESET;
        end else if (i_cfg_valid) begin
            r_seed <= i_seed_low_byte;
        end
    end

    // output slot can take a new word this cycle
    assign out_free = !r_out_vld || i_out_ready;

    slfg_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_seed      (r_seed),
        .i_in_valid  (i_in_valid),
        .i_func      (i_func),
        .i_data_byte (i_data_byte),
        .o_in_ready  (o_in_ready),
        .i_out_free  (out_free),
        .o_res       (res),
        .o_req       (mem_req),
        .i_rsp       (mem_rsp)
    );

    slfg_table u_table (
        .i_clk (i_clk),
        .i_req (mem_req),
        .o_rsp (mem_rsp)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (res.vld) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res.vld) begin
            r_out_byte <= res.data;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_byte  = r_out_byte;

endmodule

// File: rtl/core/slfg_table.sv
// ---------------------------------------------------------------------------
// slfg_table
// 55 x 8 key table: one write port, two registered read ports.
// ---------------------------------------------------------------------------
module slfg_table import slfg_pkg::*; (
    input  logic     i_clk,
    input  t_mem_req i_req,
    output t_mem_rsp o_rsp
);

    logic [7:0] r_mem [0:TBL_LEN-1];
    logic [7:0] r_rd_a;
    logic [7:0] r_rd_b;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= i_req.wr_data;
        end
    end

    // read returns old data on a same-address write
    always_ff @(posedge i_clk) begin
        if (i_req.rd_en) begin
            r_rd_a <= r_mem[i_req.rd_a_addr];
            r_rd_b <= r_mem[i_req.rd_b_addr];
        end
    end

    assign o_rsp.a = r_rd_a;
    assign o_rsp.b = r_rd_b;

endmodule

// File: rtl/core/slfg_seq.sv
// ---------------------------------------------------------------------------
// slfg_seq
// Sequencer and shared subtractor: seeding, mixing and byte steps.
// ---------------------------------------------------------------------------
`include "subtractive_lfg_keystream_xor_unit_assert.svh"

module slfg_seq import slfg_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic [7:0] i_seed,
    input  logic       i_in_valid,
    input  logic       i_func,
    input  logic [7:0] i_data_byte,
    output logic       o_in_ready,
    input  logic       i_out_free,
    output t_result    o_res,
    output t_mem_req   o_req,
    input  t_mem_rsp   i_rsp
);

    t_state r_state, n_state;

    logic [7:0]        r_prev, n_prev;
    logic [7:0]        r_cur, n_cur;
    logic [IDX_W-1:0]  r_pos, n_pos;
    logic [IDX_W-1:0]  r_k, n_k;
    logic [IDX_W-1:0]  r_i, n_i;
    logic [IDX_W-1:0]  r_oth, n_oth;
    logic [PASS_W-1:0] r_pass, n_pass;
    logic              r_mix_wr, n_mix_wr;
    logic [IDX_W-1:0]  r_mix_addr, n_mix_addr;
    logic [IDX_W-1:0]  r_lead, n_lead;
    logic [IDX_W-1:0]  r_trail, n_trail;
    logic [7:0]        r_data, n_data;

    logic [7:0] sub_a, sub_b, diff;
    logic       last_pass;

    // the one subtractor
    assign sub_a = (r_state == ST_SCATTER) ? r_prev : i_rsp.a;
    assign sub_b = (r_state == ST_SCATTER) ? r_cur  : i_rsp.b;
    assign diff  = sub_a - sub_b;

    assign last_pass = (r_pass == PASS_W'(MIX_PASSES - 1));

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_ZERO:    n_state = ST_SEED;
            ST_SEED:    n_state = ST_SCATTER;
            ST_SCATTER: if (r_k == LAST_SCATTER) n_state = ST_MIX;
            ST_MIX:     if (r_i == LAST_ENTRY && last_pass) n_state = ST_DRAIN;
            ST_DRAIN:   n_state = ST_IDLE;
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = i_func ? ST_ZERO : ST_DATA;
                end
            end
            ST_DATA:    if (i_out_free) n_state = ST_IDLE;
            default:    n_state = ST_ZERO;
        endcase
    end

    always_comb begin
        n_prev     = r_prev;
        n_cur      = r_cur;
        n_pos      = r_pos;
        n_k        = r_k;
        n_i        = r_i;
        n_oth      = r_oth;
        n_pass     = r_pass;
        n_mix_wr   = (r_state == ST_MIX);
        n_mix_addr = r_i;
        n_lead     = r_lead;
        n_trail    = r_trail;
        n_data     = r_data;
        o_req      = '0;
        o_res      = '0;
        o_in_ready = (r_state == ST_IDLE);

        // mixing write follows its read in the next cycle
        if (r_mix_wr) begin
            o_req.wr_en   = 1'b1;
            o_req.wr_addr = r_mix_addr;
            o_req.wr_data = diff;
        end

        case (r_state)
            ST_ZERO: begin
                o_req.wr_en   = 1'b1;
                o_req.wr_addr = UNHIT_ENTRY;
                o_req.wr_data = '0;
                n_prev        = i_seed;
                n_cur         = 8'd1;
                n_pos         = '0;
                n_k           = '0;
                n_i           = '0;
                n_oth         = IDX_W'(MIX_LAG);
                n_pass        = '0;
            end
            ST_SEED: begin
                o_req.wr_en   = 1'b1;
                o_req.wr_addr = SEED_ENTRY;
                o_req.wr_data = r_prev;
            end
            ST_SCATTER: begin
                o_req.wr_en   = 1'b1;
                o_req.wr_addr = r_pos;
                o_req.wr_data = r_cur;
                n_prev        = r_cur;
                n_cur         = diff;
                n_pos         = idx_stride(r_pos);
                n_k           = r_k + IDX_W'(1);
            end
            ST_MIX: begin
                o_req.rd_en     = 1'b1;
                o_req.rd_a_addr = r_i;
                o_req.rd_b_addr = r_oth;
                n_i             = idx_inc(r_i);
                n_oth           = idx_inc(r_oth);
                if (r_i == LAST_ENTRY) begin
                    n_pass = r_pass + PASS_W'(1);
                end
            end
            ST_DRAIN: begin
                n_lead  = '0;
                n_trail = IDX_W'(TRAIL_START);
            end
            ST_IDLE: begin
                if (i_in_valid && !i_func) begin
                    n_lead          = idx_inc(r_lead);
                    n_trail         = idx_inc(r_trail);
                    o_req.rd_en     = 1'b1;
                    o_req.rd_a_addr = n_lead;
                    o_req.rd_b_addr = n_trail;
                    n_data          = i_data_byte;
                end
            end
            ST_DATA: begin
                if (i_out_free) begin
                    o_req.wr_en   = 1'b1;
                    o_req.wr_addr = r_lead;
                    o_req.wr_data = diff;
                    o_res.vld     = 1'b1;
                    o_res.data    = r_data ^ diff;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_ZERO;
            r_mix_wr <= 1'b0;
            r_lead   <= '0;
            r_trail  <= IDX_W'(TRAIL_START);
        end else begin
            r_state  <= n_state;
            r_mix_wr <= n_mix_wr;
            r_lead   <= n_lead;
            r_trail  <= n_trail;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prev     <= n_prev;
        r_cur      <= n_cur;
        r_pos      <= n_pos;
        r_k        <= n_k;
        r_i        <= n_i;
        r_oth      <= n_oth;
        r_pass     <= n_pass;
        r_mix_addr <= n_mix_addr;
        r_data     <= n_data;
    end

    `SLFG_ASSERT_IMPL(a_lead_range, i_clk, i_rst_n, 1'b1, r_lead < IDX_W'(TBL_LEN))
    `SLFG_ASSERT_IMPL(a_trail_lag, i_clk, i_rst_n, 1'b1, r_trail == trail_of(r_lead))
    `SLFG_ASSERT_IMPL(a_idle_no_wr, i_clk, i_rst_n, r_state == ST_IDLE, !o_req.wr_en)
    `SLFG_ASSERT_NEXT(a_restart, i_clk, i_rst_n, o_in_ready && i_in_valid && i_func, r_state == ST_ZERO)
    `SLFG_ASSERT_NEXT(a_byte_done, i_clk, i_rst_n, o_res.vld, r_state == ST_IDLE)

endmodule

// File: bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: subtractive LFG keystream XOR unit testbench
// Drives cipher and restart words into the unit, keeps its own copy of the
// 55-byte generator table to predict every output word, and checks each word
// in order under several sender and receiver idle mixes and seed settings.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    // function codes carried on i_func
    localparam logic FUNC_CIPHER = 1'b0;
    localparam logic FUNC_RESEED = 1'b1;

    // generator geometry
    localparam int         KEY_LEN        = 55;
    localparam int         SCATTER_STEP   = 21;
    localparam int         MIX_OFFSET     = 31;
    localparam int         MIX_ROUNDS     = 4;
    localparam logic [5:0] TRAIL_INIT     = 6'd31;
    localparam logic [7:0] SEED_AT_RESET  = 8'd176;

    // a restart rebuilds the table; the wait leaves margin over the rebuild
    localparam int REBUILD_WAIT = 320;
    localparam int DRAIN_WAIT   = 20;
    localparam int CYCLE_LIMIT  = 400000;

    logic       i_clk           = 1'b0;
    logic       i_rst_n         = 1'b0;
    logic       i_cfg_valid     = 1'b0;
    logic       o_cfg_ready;
    logic [7:0] i_seed_low_byte = 8'd0;
    logic       i_in_valid      = 1'b0;
    logic       o_in_ready;
    logic       i_func          = FUNC_CIPHER;
    logic [7:0] i_data_byte     = 8'd0;
    logic       o_out_valid;
    logic       i_out_ready     = 1'b0;
    logic [7:0] o_out_byte;

    // idle mix of the current phase, in percent
    int in_idle_pct   = 0;
    int out_stall_pct = 0;

    int fail_count  = 0;
    int cycle_count = 0;

    // keystream predictor state
    logic [7:0] key_tbl [0:KEY_LEN-1];
    logic [5:0] lead_ix;
    logic [5:0] trail_ix;
    logic [7:0] seed_reg;

    // output words still owed by the unit, oldest first
    logic [7:0] pending_out_bytes [$];
    logic [7:0] want_byte;

    subtractive_lfg_keystream_xor_unit dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_seed_low_byte (i_seed_low_byte),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_func          (i_func),
        .i_data_byte     (i_data_byte),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_out_byte      (o_out_byte)
    );

    always #5 i_clk = ~i_clk;

    // hard stop if the unit hangs
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // receiver back-pressure; one draw per cycle
    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= out_stall_pct);
    end

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------

    // Rebuild the table from seed_reg. The scatter walks stride 21 over 54
    // terms, so the slot at 34 is never hit and keeps its zero; slot 54 gets
    // the seed first and is overwritten on the way. Mixing is in place, so a
    // pass sees entries it already updated.
    function automatic void reseed_table();
        logic [7:0] prev_term;
        logic [7:0] cur_term;
        logic [7:0] next_term;
        int         slot;
        prev_term = seed_reg;
        cur_term  = 8'd1;
        for (int i = 0; i < KEY_LEN; i++) begin
            key_tbl[i] = 8'd0;
        end
        key_tbl[KEY_LEN-1] = seed_reg;
        for (int k = 0; k < KEY_LEN - 1; k++) begin
            slot          = (k * SCATTER_STEP) % KEY_LEN;
            next_term     = prev_term - cur_term;
            key_tbl[slot] = cur_term;
            prev_term     = cur_term;
            cur_term      = next_term;
        end
        for (int p = 0; p < MIX_ROUNDS; p++) begin
            for (int i = 0; i < KEY_LEN; i++) begin
                key_tbl[i] = key_tbl[i] - key_tbl[(i + MIX_OFFSET) % KEY_LEN];
            end
        end
        lead_ix  = 6'd0;
        trail_ix = TRAIL_INIT;
    endfunction

    // advance both taps, fold trail into lead, XOR the fresh entry in
    function automatic logic [7:0] cipher_byte(input logic [7:0] data);
        lead_ix  = (lead_ix == 6'(KEY_LEN - 1)) ? 6'd0 : lead_ix + 6'd1;
        trail_ix = (trail_ix == 6'(KEY_LEN - 1)) ? 6'd0 : trail_ix + 6'd1;
        key_tbl[lead_ix] = key_tbl[lead_ix] - key_tbl[trail_ix];
        return data ^ key_tbl[lead_ix];
    endfunction

    // ------------------------------------------------------------------------
    // Output checker: every accepted word is matched against the oldest
    // pending prediction. Sampled in the active region of the edge, so both
    // o_out_valid and i_out_ready are their pre-edge values.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_out_bytes.size() == 0) begin
                $error("out_byte: no word expected, got %02h", o_out_byte);
                fail_count++;
            end else begin
                want_byte = pending_out_bytes.pop_front();
                if (o_out_byte !== want_byte) begin
                    $error("out_byte: expected %02h, got %02h", want_byte, o_out_byte);
                    fail_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Driver tasks
    // ------------------------------------------------------------------------

    // Offer one input word and return at the edge that takes it. Valid is
    // left high afterwards so the next call can follow back to back; each
    // cycle sees at most one update of i_in_valid.
    task automatic send_word(input logic func, input logic [7:0] data);
        while ($urandom_range(99) < in_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_func      <= func;
        i_data_byte <= data;
        do @(posedge i_clk); while (!o_in_ready);
        if (func == FUNC_RESEED) begin
            reseed_table();
        end else begin
            pending_out_bytes.push_back(cipher_byte(data));
        end
    endtask

    // Drop valid, let every owed word come out, then cover a table rebuild
    // that may still be running after a restart word.
    task automatic wait_quiet();
        i_in_valid <= 1'b0;
        while (pending_out_bytes.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (REBUILD_WAIT) @(posedge i_clk);
    endtask

    // seed write; only used while the unit is quiet
    task automatic write_seed(input logic [7:0] seed);
        i_cfg_valid     <= 1'b1;
        i_seed_low_byte <= seed;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        seed_reg = seed;
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // table as built at reset from the default seed
    task automatic test_reset_keystream();
        send_word(FUNC_CIPHER, 8'h00);
        send_word(FUNC_CIPHER, 8'hFF);
        send_word(FUNC_CIPHER, 8'h01);
        send_word(FUNC_CIPHER, 8'h80);
    endtask

    // restart mid-stream rewinds the taps; its data byte is don't-care
    task automatic test_restart_mid_stream();
        send_word(FUNC_RESEED, 8'hFF);
        send_word(FUNC_CIPHER, 8'h00);
        send_word(FUNC_CIPHER, 8'hA5);
    endtask

    // seed extremes; a new seed must not touch the live table until restart
    task automatic test_seed_extremes();
        wait_quiet();
        write_seed(8'h00);
        send_word(FUNC_CIPHER, 8'h55);
        send_word(FUNC_RESEED, 8'h00);
        send_word(FUNC_CIPHER, 8'h00);
        send_word(FUNC_CIPHER, 8'hFF);
        send_word(FUNC_CIPHER, 8'h5A);
        wait_quiet();
        write_seed(8'hFF);
        send_word(FUNC_CIPHER, 8'hAA);
        send_word(FUNC_RESEED, 8'h7E);
        send_word(FUNC_CIPHER, 8'h00);
        send_word(FUNC_CIPHER, 8'hFF);
        send_word(FUNC_CIPHER, 8'h3C);
    endtask

    // two restarts back to back, then data
    task automatic test_double_restart();
        send_word(FUNC_RESEED, 8'h00);
        send_word(FUNC_RESEED, 8'h81);
        send_word(FUNC_CIPHER, 8'h42);
    endtask

    // long run without restart so both taps wrap the table a few times
    task automatic test_tap_wrap();
        repeat (150) send_word(FUNC_CIPHER, 8'($urandom_range(255)));
    endtask

    // Random traffic under one idle mix: fresh seed, restart, then mostly
    // cipher words with the odd restart sprinkled in.
    task automatic test_random_phase(input int idle_pct, input int stall_pct,
                                     input int n_words);
        logic func;
        wait_quiet();
        in_idle_pct   = idle_pct;
        out_stall_pct = stall_pct;
        write_seed(8'($urandom_range(255)));
        send_word(FUNC_RESEED, 8'($urandom_range(255)));
        repeat (n_words) begin
            func = ($urandom_range(99) < 3) ? FUNC_RESEED : FUNC_CIPHER;
            send_word(func, 8'($urandom_range(255)));
        end
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial begin
        seed_reg = SEED_AT_RESET;
        reseed_table();

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed words, no idling
        test_reset_keystream();
        test_restart_mid_stream();
        test_seed_extremes();
        test_double_restart();
        test_tap_wrap();

        // random words: clean, sender idle, receiver stall, both
        test_random_phase(0, 0, 260);
        test_random_phase(58, 0, 260);
        test_random_phase(0, 58, 260);
        test_random_phase(34, 34, 260);

        i_in_valid <= 1'b0;
        while (pending_out_bytes.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_WAIT) @(posedge i_clk);

        if (fail_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

// File: filelist.f
+incdir+rtl/core
rtl/core/slfg_pkg.sv
rtl/core/slfg_table.sv
rtl/core/slfg_seq.sv
rtl/core/subtractive_lfg_keystream_xor_unit.sv
bench/tb_top.sv
